FILE: hdl/ascon_pkg.sv
`default_nettype none

package ascon_pkg;

  // permutation geometry
  localparam int unsigned ROUNDS      = 12;
  localparam int unsigned FIRST_ROUND = 12 - ROUNDS;
  localparam int unsigned RND_W       = 4;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned NUM_WORDS   = 5;

  // configuration port geometry
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // register indexes, taken from paddr[2]
  localparam logic REG_OUTER = 1'b0;
  localparam logic REG_INNER = 1'b1;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [NUM_WORDS-1:0] state_t;

  // linear layer rotation amounts per word
  localparam int unsigned ROT_A [NUM_WORDS] = '{19, 61, 1, 10, 7};
  localparam int unsigned ROT_B [NUM_WORDS] = '{28, 39, 6, 17, 41};

  // round constant k of the twelve-round schedule: ((15 - k) << 4) | k
  function automatic logic [7:0] round_const(input logic [RND_W-1:0] k);
    logic [3:0] hi;
    hi = 4'd15 - k;
    return {hi, k};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/ascon_in_if.sv
`default_nettype none

interface ascon_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] state_word_0;
  logic [63:0] state_word_1;
  logic [63:0] state_word_2;
  logic [63:0] state_word_3;
  logic [63:0] state_word_4;

  modport source (
    output valid, state_word_0, state_word_1, state_word_2, state_word_3, state_word_4,
    input  ready
  );
  modport sink (
    input  valid, state_word_0, state_word_1, state_word_2, state_word_3, state_word_4,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/ascon_out_if.sv
`default_nettype none

interface ascon_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_word_0;
  logic [63:0] out_word_1;
  logic [63:0] out_word_2;
  logic [63:0] out_word_3;
  logic [63:0] out_word_4;

  modport source (
    output valid, out_word_0, out_word_1, out_word_2, out_word_3, out_word_4,
    input  ready
  );
  modport sink (
    input  valid, out_word_0, out_word_1, out_word_2, out_word_3, out_word_4,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/ascon_round.sv
`default_nettype none

module ascon_round import ascon_pkg::*; (
  input  state_t     state_i,
  input  logic [7:0] rc_i,
  output state_t     state_o
);

  function automatic word_t rotr(input word_t v, input int unsigned n);
    return (v >> n) | (v << (WORD_W - n));
  endfunction

  word_t x0, x1, x2, x3, x4;
  word_t t0, t1, t2, t3, t4;
  state_t sbox;

  // constant addition and bitsliced s-box
  always_comb begin
    x0 = state_i[0];
    x1 = state_i[1];
    x2 = state_i[2] ^ {56'd0, rc_i};
    x3 = state_i[3];
    x4 = state_i[4];

    x0 = x0 ^ x4;
    x4 = x4 ^ x3;
    x2 = x2 ^ x1;
    t0 = ~x0 & x1;
    t1 = ~x1 & x2;
    t2 = ~x2 & x3;
    t3 = ~x3 & x4;
    t4 = ~x4 & x0;
    x0 = x0 ^ t1;
    x1 = x1 ^ t2;
    x2 = x2 ^ t3;
    x3 = x3 ^ t4;
    x4 = x4 ^ t0;
    x1 = x1 ^ x0;
    x0 = x0 ^ x4;
    x3 = x3 ^ x2;
    x2 = ~x2;

    sbox[0] = x0;
    sbox[1] = x1;
    sbox[2] = x2;
    sbox[3] = x3;
    sbox[4] = x4;
  end

  // linear diffusion, one pair of rotations per word
  for (genvar i = 0; i < NUM_WORDS; i++) begin : g_lin
    assign state_o[i] = sbox[i] ^ rotr(sbox[i], ROT_A[i]) ^ rotr(sbox[i], ROT_B[i]);
  end

endmodule

`default_nettype wire

FILE: hdl/ascon_permutation.sv
`default_nettype none

// Ascon permutation engine. An item is a 320-bit state in five 64-bit words; the block
// applies the 12-round permutation outer_repeats * inner_repeats times and returns one
// item with the final words. One round unit is reused every cycle. When the last round
// is done the state is moved into the output register, and the next item can be taken
// after that move. With either count zero no round is applied and the state comes back
// unchanged. The input is not ready while an item is in work. A finished item waits in
// an output register, so the next item can be taken before the previous result is read.
// If that register is still full when the next item finishes, the block holds until it
// is read. Registers at byte address 0 (outer_repeats) and 4 (inner_repeats), 16 bits
// each, reset to 1; write them only while the block is idle.
module ascon_permutation import ascon_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  ascon_in_if.sink               in_if,
  ascon_out_if.source            out_if
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [RND_W-1:0] LAST_ROUND  = RND_W'(ROUNDS - 1);
  localparam logic [RND_W-1:0] FIRST_INDEX = RND_W'(FIRST_ROUND);

  logic [1:0]       fsm_q;
  logic [RND_W-1:0] round_q;
  logic [CNT_W-1:0] inner_cnt_q, outer_cnt_q;
  logic [CNT_W-1:0] outer_q, inner_q;
  logic             out_valid_q;
  state_t           state_q, out_q, round_out;
  logic             in_fire, out_free, cfg_wr, zero_count;

  assign in_fire    = in_if.valid && in_if.ready;
  assign out_free   = !out_valid_q || out_if.ready;
  assign cfg_wr     = psel && penable && pwrite;
  assign zero_count = (outer_q == '0) || (inner_q == '0);

  // handshake outputs
  assign in_if.ready  = (fsm_q == ST_IDLE);
  assign out_if.valid = out_valid_q;
  assign out_if.out_word_0 = out_q[0];
  assign out_if.out_word_1 = out_q[1];
  assign out_if.out_word_2 = out_q[2];
  assign out_if.out_word_3 = out_q[3];
  assign out_if.out_word_4 = out_q[4];

  // register read back
  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      REG_OUTER: prdata = {{(DATA_W-CNT_W){1'b0}}, outer_q};
      REG_INNER: prdata = {{(DATA_W-CNT_W){1'b0}}, inner_q};
      default:   prdata = '0;
    endcase
  end

  // shared round unit
  ascon_round u_round (
    .state_i (state_q),
    .rc_i    (round_const(FIRST_INDEX + round_q)),
    .state_o (round_out)
  );

  // sequencer: round, inner and outer counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= ST_IDLE;
      round_q     <= '0;
      inner_cnt_q <= '0;
      outer_cnt_q <= '0;
      outer_q     <= CNT_W'(1);
      inner_q     <= CNT_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[2])
          REG_OUTER: outer_q <= pwdata[CNT_W-1:0];
          REG_INNER: inner_q <= pwdata[CNT_W-1:0];
          default: ;
        endcase
      end

      if (out_if.valid && out_if.ready) begin
        out_valid_q <= 1'b0;
      end

      case (fsm_q)
        ST_IDLE: begin
          if (in_fire) begin
            round_q     <= '0;
            inner_cnt_q <= '0;
            outer_cnt_q <= '0;
            fsm_q       <= zero_count ? ST_DONE : ST_RUN;
          end
        end
        ST_RUN: begin
          if (round_q == LAST_ROUND) begin
            round_q <= '0;
            if (inner_cnt_q == inner_q - CNT_W'(1)) begin
              inner_cnt_q <= '0;
              if (outer_cnt_q == outer_q - CNT_W'(1)) begin
                fsm_q <= ST_DONE;
              end else begin
                outer_cnt_q <= outer_cnt_q + CNT_W'(1);
              end
            end else begin
              inner_cnt_q <= inner_cnt_q + CNT_W'(1);
            end
          end else begin
            round_q <= round_q + RND_W'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            fsm_q       <= ST_IDLE;
          end
        end
        default: fsm_q <= ST_IDLE;
      endcase
    end
  end

  // working state and output register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      state_q[0] <= in_if.state_word_0;
      state_q[1] <= in_if.state_word_1;
      state_q[2] <= in_if.state_word_2;
      state_q[3] <= in_if.state_word_3;
      state_q[4] <= in_if.state_word_4;
    end else if (fsm_q == ST_RUN) begin
      state_q <= round_out;
    end
    if ((fsm_q == ST_DONE) && out_free) begin
      out_q <= state_q;
    end
  end

endmodule

`default_nettype wire

FILE: tb/ascon_permutation_checker.sv
`timescale 1ns / 1ps

// watches the config port and both channels, predicts each permuted state
// and compares it with the item that comes out
module ascon_permutation_checker import ascon_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  input  wire logic [DATA_W-1:0] prdata,
  input  wire logic              pready,
  ascon_in_if                    in_if,
  ascon_out_if                   out_if,
  output int unsigned            fail_count_o,
  output int unsigned            pending_o
);

  // round constants of the twelve-round schedule
  localparam logic [7:0] RC_TABLE [12] = '{
    8'hF0, 8'hE1, 8'hD2, 8'hC3, 8'hB4, 8'hA5,
    8'h96, 8'h87, 8'h78, 8'h69, 8'h5A, 8'h4B
  };
  // rotation pairs of the diffusion layer, per word
  localparam int unsigned SHIFT_A [NUM_WORDS] = '{19, 61, 1, 10, 7};
  localparam int unsigned SHIFT_B [NUM_WORDS] = '{28, 39, 6, 17, 41};

  logic [CNT_W-1:0] outer_count;
  logic [CNT_W-1:0] inner_count;
  state_t           permuted_q [$];
  int unsigned      mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic word_t rotr(word_t v, int unsigned n);
    return (v >> n) | (v << (WORD_W - n));
  endfunction

  function automatic state_t ascon_round(state_t s, logic [7:0] rc);
    word_t t0, t1, t2, t3, t4;
    s[2] = s[2] ^ word_t'(rc);
    // bitsliced s-box
    s[0] = s[0] ^ s[4];
    s[4] = s[4] ^ s[3];
    s[2] = s[2] ^ s[1];
    t0 = ~s[0] & s[1];
    t1 = ~s[1] & s[2];
    t2 = ~s[2] & s[3];
    t3 = ~s[3] & s[4];
    t4 = ~s[4] & s[0];
    s[0] = s[0] ^ t1;
    s[1] = s[1] ^ t2;
    s[2] = s[2] ^ t3;
    s[3] = s[3] ^ t4;
    s[4] = s[4] ^ t0;
    s[1] = s[1] ^ s[0];
    s[0] = s[0] ^ s[4];
    s[3] = s[3] ^ s[2];
    s[2] = ~s[2];
    // linear diffusion
    for (int i = 0; i < NUM_WORDS; i++) begin
      s[i] = s[i] ^ rotr(s[i], SHIFT_A[i]) ^ rotr(s[i], SHIFT_B[i]);
    end
    return s;
  endfunction

  function automatic state_t permute_repeated(state_t s, logic [CNT_W-1:0] outer,
                                              logic [CNT_W-1:0] inner);
    longint unsigned total;
    total = outer;
    total = total * inner;
    for (longint unsigned k = 0; k < total; k++) begin
      for (int unsigned r = 0; r < ROUNDS; r++) begin
        s = ascon_round(s, RC_TABLE[(12 - ROUNDS + r) % 12]);
      end
    end
    return s;
  endfunction

  task automatic check_word(string what, word_t want, word_t got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
    end
  endtask

  // register shadow, expected states, result compare
  always @(posedge clk_i or negedge rst_ni) begin
    state_t got;
    state_t want;
    if (!rst_ni) begin
      outer_count = 1;
      inner_count = 1;
      permuted_q.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_INNER) inner_count = pwdata[CNT_W-1:0];
          else outer_count = pwdata[CNT_W-1:0];
        end else begin
          want[0] = (paddr[2] == REG_INNER) ? word_t'(inner_count) : word_t'(outer_count);
          check_word("prdata", want[0], word_t'(prdata));
        end
      end
      if (in_if.valid && in_if.ready) begin
        got = {in_if.state_word_4, in_if.state_word_3, in_if.state_word_2,
               in_if.state_word_1, in_if.state_word_0};
        permuted_q.insert(permuted_q.size(), permute_repeated(got, outer_count, inner_count));
      end
      if (out_if.valid && out_if.ready) begin
        got = {out_if.out_word_4, out_if.out_word_3, out_if.out_word_2,
               out_if.out_word_1, out_if.out_word_0};
        if (permuted_q.size() == 0) begin
          mismatches++;
          $display("%0t: item with no expected state, expected none got %h", $time, got);
        end else begin
          want = permuted_q.pop_front();
          for (int i = 0; i < NUM_WORDS; i++) begin
            check_word($sformatf("out_word_%0d", i), want[i], got[i]);
          end
        end
      end
    end
    pending_o <= permuted_q.size();
  end

endmodule

FILE: tb/tb_ascon_permutation.sv
`timescale 1ns / 1ps

module tb_ascon_permutation;
  import ascon_pkg::*;

  localparam int unsigned ITEM_TARGET = 1150;

  typedef enum int unsigned {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_e;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int unsigned       fail_count;
  int unsigned       pending;
  int unsigned       src_pct;
  int unsigned       snk_pct;
  int unsigned       items_sent = 0;
  logic [CNT_W-1:0]  cur_outer = CNT_W'(1);
  logic [CNT_W-1:0]  cur_inner = CNT_W'(1);
  longint unsigned   quiet_cycles = 0;
  longint unsigned   quiet_limit;

  ascon_in_if  in_if ();
  ascon_out_if out_if ();

  ascon_permutation uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_if   (in_if),
    .out_if  (out_if)
  );

  ascon_permutation_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_if        (in_if),
    .out_if       (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // receiver side stalls
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= snk_pct);
  end

  // watchdog, sized from the slowest item under the current counts
  assign quiet_limit = 4 * (12 * longint'(cur_outer) * longint'(cur_inner) + 4) + 5000;

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= quiet_limit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idle(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        src_pct = 0;
        snk_pct = 0;
      end
      IDLE_SRC: begin
        src_pct = 63;
        snk_pct = 0;
      end
      IDLE_SNK: begin
        src_pct = 0;
        snk_pct = 63;
      end
      default: begin
        src_pct = 13;
        snk_pct = 13;
      end
    endcase
  endtask

  // offer one state and hold it until taken
  task automatic push_state(state_t s);
    while ($urandom_range(99) < src_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.state_word_0 <= s[0];
    in_if.state_word_1 <= s[1];
    in_if.state_word_2 <= s[2];
    in_if.state_word_3 <= s[3];
    in_if.state_word_4 <= s[4];
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  // stop sending and wait for every result
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(logic write, logic idx, logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (write) begin
      if (idx == REG_INNER) cur_inner = data[CNT_W-1:0];
      else cur_outer = data[CNT_W-1:0];
    end
    @(posedge clk_i);
  endtask

  task automatic configure(logic [CNT_W-1:0] outer, logic [CNT_W-1:0] inner);
    logic [DATA_W-CNT_W-1:0] junk;
    drain();
    junk = '0;
    if ($urandom_range(3) == 0) junk = (DATA_W-CNT_W)'($urandom);
    if ($urandom_range(1)) begin
      apb_access(1'b1, REG_OUTER, {junk, outer});
      apb_access(1'b1, REG_INNER, {junk, inner});
    end else begin
      apb_access(1'b1, REG_INNER, {junk, inner});
      apb_access(1'b1, REG_OUTER, {junk, outer});
    end
    apb_access(1'b0, REG_OUTER, '0);
    apb_access(1'b0, REG_INNER, '0);
  endtask

  function automatic word_t random_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(63);
      3:       return ~(word_t'(1) << $urandom_range(63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic state_t random_state();
    state_t s;
    for (int i = 0; i < NUM_WORDS; i++) s[i] = random_word();
    return s;
  endfunction

  // mostly one to three permutations, now and then none or four to six
  function automatic logic [CNT_W-1:0] random_count();
    case ($urandom_range(9))
      0:               return '0;
      1, 2, 3, 4, 5:   return CNT_W'(1);
      6, 7, 8:         return CNT_W'($urandom_range(2, 3));
      default:         return CNT_W'($urandom_range(4, 6));
    endcase
  endfunction

  initial begin
    state_t      s;
    int unsigned phase;
    int unsigned n;

    rst_ni             <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_if.valid        <= 1'b0;
    in_if.state_word_0 <= '0;
    in_if.state_word_1 <= '0;
    in_if.state_word_2 <= '0;
    in_if.state_word_3 <= '0;
    in_if.state_word_4 <= '0;
    set_idle(IDLE_NONE);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of both counts
    apb_access(1'b0, REG_OUTER, '0);
    apb_access(1'b0, REG_INNER, '0);

    // directed states at one permutation
    push_state('0);
    push_state('1);
    push_state({NUM_WORDS{64'hAAAA_AAAA_AAAA_AAAA}});
    push_state({NUM_WORDS{64'h5555_5555_5555_5555}});
    for (int k = 0; k < NUM_WORDS; k++) begin
      s    = '0;
      s[k] = 64'h1;
      push_state(s);
    end
    push_state({NUM_WORDS{64'h8000_0000_0000_0000}});
    // word 2 cancels the first round constant
    s    = '0;
    s[2] = 64'hF0;
    push_state(s);
    push_state({64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                64'hDEAD_BEEF_0BAD_F00D, 64'h0F0F_0F0F_F0F0_F0F0, 64'h8000_0000_0000_0001});

    // zero counts pass the state through
    configure(16'd0, 16'd5);
    push_state(random_state());
    push_state(random_state());
    configure(16'd3, 16'd0);
    push_state(random_state());
    configure(16'hFFFF, 16'd0);
    push_state(random_state());
    configure(16'd0, 16'hFFFF);
    push_state(random_state());
    // several permutations in a row
    configure(16'd2, 16'd3);
    push_state(random_state());
    // longest outer count
    configure(16'hFFFF, 16'd1);
    push_state(random_state());

    // random phases, each with its own counts and idle pattern
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      configure(random_count(), random_count());
      set_idle(idle_mode_e'(phase % 4));
      n = $urandom_range(30, 70);
      repeat (n) begin
        if ($urandom_range(49) == 0) drain();
        push_state(random_state());
      end
      phase++;
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
